// File: hw/rtl/psbb_pkg.sv
// Shared constants, types and arithmetic helpers of the sector bounding box block.
`timescale 1ns / 1ps
package psbb_pkg;

    localparam int IN_W     = 16;
    localparam int OUT_W    = 17;
    localparam int CORDIC_N = 24;
    localparam int XY_W     = 34;
    localparam int Z_W      = 32;
    localparam int TRIG_W   = 16;

    localparam logic signed [XY_W-1:0] X_INIT  = 34'sh0_26DD_3B6A;
    localparam logic [TRIG_W-1:0]      ONE_Q15 = 16'd32768;

    localparam logic [1:0] QUAD_I   = 2'd0;
    localparam logic [1:0] QUAD_II  = 2'd1;
    localparam logic [1:0] QUAD_III = 2'd2;
    localparam logic [1:0] QUAD_IV  = 2'd3;

    localparam logic signed [Z_W-1:0] ATAN [0:CORDIC_N-1] = '{
        32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756,
        32'sd42667331,  32'sd21354465,  32'sd10679838,  32'sd5340245,
        32'sd2670163,   32'sd1335087,   32'sd667544,    32'sd333772,
        32'sd166886,    32'sd83443,     32'sd41722,     32'sd20861,
        32'sd10430,     32'sd5215,      32'sd2608,      32'sd1304,
        32'sd652,       32'sd326,       32'sd163,       32'sd81
    };

    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
    } t_rot;

    typedef struct packed {
        logic signed [OUT_W-1:0] sn;
        logic signed [OUT_W-1:0] cs;
    } t_sc;

    function automatic t_rot rot_step(t_rot v, int i);
        t_rot r;
        logic signed [XY_W-1:0] dx;
        logic signed [XY_W-1:0] dy;
        dx = v.y >>> i;
        dy = v.x >>> i;
        if (!v.z[Z_W-1]) begin
            r.x = v.x - dx;
            r.y = v.y + dy;
            r.z = v.z - ATAN[i];
        end else begin
            r.x = v.x + dx;
            r.y = v.y - dy;
            r.z = v.z + ATAN[i];
        end
        return r;
    endfunction

    function automatic logic [TRIG_W-1:0] q15_round(logic signed [XY_W-1:0] v);
        logic signed [XY_W-1:0] w;
        logic [TRIG_W-1:0] r;
        w = (v + 34'sd16384) >>> 15;
        if (w < 0) begin
            r = '0;
        end else if (w > $signed({18'd0, ONE_Q15})) begin
            r = ONE_Q15;
        end else begin
            r = w[TRIG_W-1:0];
        end
        return r;
    endfunction

    function automatic t_sc quad_map(logic [1:0] q, logic [TRIG_W-1:0] s,
                                     logic [TRIG_W-1:0] c);
        t_sc r;
        logic signed [OUT_W-1:0] ps;
        logic signed [OUT_W-1:0] pc;
        ps = $signed({1'b0, s});
        pc = $signed({1'b0, c});
        unique case (q)
            QUAD_I: begin
                r.sn = ps;
                r.cs = pc;
            end
            QUAD_II: begin
                r.sn = pc;
                r.cs = -ps;
            end
            QUAD_III: begin
                r.sn = -ps;
                r.cs = -pc;
            end
            default: begin
                r.sn = -pc;
                r.cs = ps;
            end
        endcase
        return r;
    endfunction

    function automatic logic signed [OUT_W-1:0] smin(logic signed [OUT_W-1:0] a,
                                                     logic signed [OUT_W-1:0] b);
        return (a < b) ? a : b;
    endfunction

    function automatic logic signed [OUT_W-1:0] smax(logic signed [OUT_W-1:0] a,
                                                     logic signed [OUT_W-1:0] b);
        return (a > b) ? a : b;
    endfunction

endpackage

// File: hw/rtl/psbb_if.sv
// Valid/ready channel interfaces for sector items and bounding box items.
`timescale 1ns / 1ps
interface psbb_in_if;
    logic                           valid;
    logic                           ready;
    logic [psbb_pkg::IN_W-1:0]      angle_start;
    logic [psbb_pkg::IN_W-1:0]      angle_end;
    logic [psbb_pkg::IN_W-1:0]      radius_inner;
    logic [psbb_pkg::IN_W-1:0]      radius_outer;

    modport source (output valid, angle_start, angle_end, radius_inner, radius_outer,
                    input ready);
    modport sink (input valid, angle_start, angle_end, radius_inner, radius_outer,
                  output ready);
endinterface

interface psbb_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [psbb_pkg::OUT_W-1:0]  box_left;
    logic signed [psbb_pkg::OUT_W-1:0]  box_top;
    logic signed [psbb_pkg::OUT_W-1:0]  box_right;
    logic signed [psbb_pkg::OUT_W-1:0]  box_bottom;

    modport source (output valid, box_left, box_top, box_right, box_bottom,
                    input ready);
    modport sink (input valid, box_left, box_top, box_right, box_bottom,
                  output ready);
endinterface

// File: hw/rtl/polar_sector_bounding_box.sv
// Bounding box of an annular sector: a fully pipelined unit that takes one sector
// item per clock unless the output stalls. The pipe holds the capture register and
// the two 24-step CORDIC rotators (one register per step), followed by rounding,
// multiplication, product rounding and the side selection with the output
// register. All stages advance together; a stall at the output holds the whole
// pipe and the input is not ready during that cycle.
`timescale 1ns / 1ps
module polar_sector_bounding_box #(
    parameter int ANGLE_BITS  = 16,
    parameter int RADIUS_BITS = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    psbb_in_if.sink         i_in_ch,
    psbb_out_if.source      o_out_ch
);

    localparam int NS  = psbb_pkg::CORDIC_N;
    localparam int OW  = psbb_pkg::OUT_W;
    localparam int TW  = psbb_pkg::TRIG_W;
    localparam int PW  = RADIUS_BITS + TW;
    localparam int MW  = (RADIUS_BITS + 2 > OW) ? RADIUS_BITS + 2 : OW;
    localparam int OFF = ANGLE_BITS - 2;

    localparam int D1S1 = 0;
    localparam int D1C1 = 1;
    localparam int D1S2 = 2;
    localparam int D1C2 = 3;
    localparam int D2S1 = 4;
    localparam int D2C1 = 5;
    localparam int D2S2 = 6;
    localparam int D2C2 = 7;

    typedef struct packed {
        logic                   vld;
        logic [ANGLE_BITS-1:0]  a1;
        logic [ANGLE_BITS-1:0]  a2;
        logic [RADIUS_BITS-1:0] d1;
        logic [RADIUS_BITS-1:0] d2;
        logic                   zero1;
        logic                   zero2;
        psbb_pkg::t_rot         r1;
        psbb_pkg::t_rot         r2;
    } t_cs;

    typedef struct packed {
        logic                   vld;
        logic [ANGLE_BITS-1:0]  a1;
        logic [ANGLE_BITS-1:0]  a2;
        logic [RADIUS_BITS-1:0] d1;
        logic [RADIUS_BITS-1:0] d2;
        psbb_pkg::t_sc          t1;
        psbb_pkg::t_sc          t2;
    } t_ts;

    logic adv;
    t_cs  r_cs [0:NS];
    t_cs  n_cs0;
    t_ts  r_ts;
    t_ts  n_ts;

    assign adv            = !o_out_ch.valid || o_out_ch.ready;
    assign i_in_ch.ready  = adv;

    // stage 0: capture and set up the rotators
    always_comb begin
        n_cs0       = '0;
        n_cs0.vld   = i_in_ch.valid;
        n_cs0.a1    = ANGLE_BITS'(i_in_ch.angle_start);
        n_cs0.a2    = ANGLE_BITS'(i_in_ch.angle_end);
        n_cs0.d1    = RADIUS_BITS'(i_in_ch.radius_inner);
        n_cs0.d2    = RADIUS_BITS'(i_in_ch.radius_outer);
        n_cs0.zero1 = (n_cs0.a1[OFF-1:0] == '0);
        n_cs0.zero2 = (n_cs0.a2[OFF-1:0] == '0);
        n_cs0.r1.x  = psbb_pkg::X_INIT;
        n_cs0.r1.y  = '0;
        n_cs0.r1.z  = psbb_pkg::Z_W'({n_cs0.a1[OFF-1:0], {(32 - ANGLE_BITS){1'b0}}});
        n_cs0.r2.x  = psbb_pkg::X_INIT;
        n_cs0.r2.y  = '0;
        n_cs0.r2.z  = psbb_pkg::Z_W'({n_cs0.a2[OFF-1:0], {(32 - ANGLE_BITS){1'b0}}});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cs[0].vld <= 1'b0;
        end else if (adv) begin
            r_cs[0] <= n_cs0;
        end
    end

    for (genvar k = 0; k < NS; k++) begin : g_rot
        t_cs n_cs;
        always_comb begin
            n_cs    = r_cs[k];
            n_cs.r1 = psbb_pkg::rot_step(r_cs[k].r1, k);
            n_cs.r2 = psbb_pkg::rot_step(r_cs[k].r2, k);
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_cs[k+1].vld <= 1'b0;
            end else if (adv) begin
                r_cs[k+1] <= n_cs;
            end
        end
    end

    // rounding to Q1.15 and quadrant mapping
    always_comb begin
        logic [TW-1:0] s1;
        logic [TW-1:0] c1;
        logic [TW-1:0] s2;
        logic [TW-1:0] c2;
        s1 = r_cs[NS].zero1 ? '0 : psbb_pkg::q15_round(r_cs[NS].r1.y);
        c1 = r_cs[NS].zero1 ? psbb_pkg::ONE_Q15 : psbb_pkg::q15_round(r_cs[NS].r1.x);
        s2 = r_cs[NS].zero2 ? '0 : psbb_pkg::q15_round(r_cs[NS].r2.y);
        c2 = r_cs[NS].zero2 ? psbb_pkg::ONE_Q15 : psbb_pkg::q15_round(r_cs[NS].r2.x);
        n_ts.vld = r_cs[NS].vld;
        n_ts.a1  = r_cs[NS].a1;
        n_ts.a2  = r_cs[NS].a2;
        n_ts.d1  = r_cs[NS].d1;
        n_ts.d2  = r_cs[NS].d2;
        n_ts.t1  = psbb_pkg::quad_map(r_cs[NS].a1[ANGLE_BITS-1 -: 2], s1, c1);
        n_ts.t2  = psbb_pkg::quad_map(r_cs[NS].a2[ANGLE_BITS-1 -: 2], s2, c2);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ts.vld <= 1'b0;
        end else if (adv) begin
            r_ts <= n_ts;
        end
    end

    // raw magnitude products
    logic                   r_pm_vld;
    logic [ANGLE_BITS-1:0]  r_pm_a1;
    logic [ANGLE_BITS-1:0]  r_pm_a2;
    logic [RADIUS_BITS-1:0] r_pm_d1;
    logic [RADIUS_BITS-1:0] r_pm_d2;
    logic [PW-1:0]          r_pm [0:7];
    logic                   r_pm_neg [0:7];
    logic signed [OW-1:0]   tv [0:3];

    assign tv[0] = r_ts.t1.sn;
    assign tv[1] = r_ts.t1.cs;
    assign tv[2] = r_ts.t2.sn;
    assign tv[3] = r_ts.t2.cs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pm_vld <= 1'b0;
        end else if (adv) begin
            r_pm_vld <= r_ts.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_pm_a1 <= r_ts.a1;
            r_pm_a2 <= r_ts.a2;
            r_pm_d1 <= r_ts.d1;
            r_pm_d2 <= r_ts.d2;
        end
    end

    for (genvar j = 0; j < 8; j++) begin : g_mul
        logic signed [OW-1:0] abs_t;
        logic [TW-1:0]        mag;
        logic [RADIUS_BITS-1:0] rad;
        assign abs_t = tv[j % 4][OW-1] ? -tv[j % 4] : tv[j % 4];
        assign mag   = abs_t[TW-1:0];
        assign rad   = (j < 4) ? r_ts.d1 : r_ts.d2;
        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_pm[j]     <= PW'(rad) * PW'(mag);
                r_pm_neg[j] <= tv[j % 4][OW-1];
            end
        end
    end

    // rounding and saturation of the products
    logic                   r_pr_vld;
    logic [ANGLE_BITS-1:0]  r_pr_a1;
    logic [ANGLE_BITS-1:0]  r_pr_a2;
    logic signed [OW-1:0]   r_pr [0:7];
    logic signed [OW-1:0]   r_p1;
    logic signed [OW-1:0]   r_p2;
    logic [MW-1:0]          dm1;
    logic [MW-1:0]          dm2;

    assign dm1 = MW'(r_pm_d1);
    assign dm2 = MW'(r_pm_d2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pr_vld <= 1'b0;
        end else if (adv) begin
            r_pr_vld <= r_pm_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_pr_a1 <= r_pm_a1;
            r_pr_a2 <= r_pm_a2;
            r_p1    <= (dm1 > MW'(65535)) ? OW'(65535) : $signed(OW'(dm1));
            r_p2    <= (dm2 > MW'(65535)) ? OW'(65535) : $signed(OW'(dm2));
        end
    end

    for (genvar j = 0; j < 8; j++) begin : g_rnd
        logic [PW:0]          sum;
        logic [MW-1:0]        m;
        logic signed [OW-1:0] pos;
        assign sum = {1'b0, r_pm[j]} + (PW+1)'(16384);
        assign m   = MW'(sum[PW:15]);
        assign pos = (m > MW'(65535)) ? OW'(65535) : $signed(OW'(m));
        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_pr[j] <= r_pm_neg[j] ? -pos : pos;
            end
        end
    end

    // side selection
    logic                 r_o_vld;
    logic signed [OW-1:0] r_left;
    logic signed [OW-1:0] r_top;
    logic signed [OW-1:0] r_right;
    logic signed [OW-1:0] r_bottom;
    logic signed [OW-1:0] n_left;
    logic signed [OW-1:0] n_ymax;
    logic signed [OW-1:0] n_right;
    logic signed [OW-1:0] n_ymin;
    logic [1:0]           q1;
    logic [1:0]           q2;
    logic                 lt;

    assign q1 = r_pr_a1[ANGLE_BITS-1 -: 2];
    assign q2 = r_pr_a2[ANGLE_BITS-1 -: 2];
    assign lt = r_pr_a2 < r_pr_a1;

    always_comb begin
        unique case (q1)
            psbb_pkg::QUAD_I: begin
                priority if (lt)                      n_left = -r_p2;
                else if (q2 == psbb_pkg::QUAD_I)      n_left = r_pr[D1C2];
                else if (q2 == psbb_pkg::QUAD_II)     n_left = r_pr[D2C2];
                else                                  n_left = -r_p2;
            end
            psbb_pkg::QUAD_II: begin
                priority if (q2 == psbb_pkg::QUAD_I)  n_left = -r_p2;
                else if (q2 == psbb_pkg::QUAD_II)     n_left = r_pr[D2C2];
                else                                  n_left = -r_p2;
            end
            psbb_pkg::QUAD_III: begin
                priority if (q2 == psbb_pkg::QUAD_I)  n_left = r_pr[D2C1];
                else if (lt)    n_left = psbb_pkg::smin(r_pr[D2C1], r_pr[D2C2]);
                else                                  n_left = r_pr[D2C1];
            end
            default: begin
                priority if (q2 == psbb_pkg::QUAD_I)
                    n_left = psbb_pkg::smin(r_pr[D1C1], r_pr[D1C2]);
                else if (q2 == psbb_pkg::QUAD_II)     n_left = r_pr[D2C2];
                else if (lt)                          n_left = -r_p2;
                else                                  n_left = r_pr[D1C1];
            end
        endcase
    end

    always_comb begin
        unique case (q1)
            psbb_pkg::QUAD_I: begin
                priority if (lt)                      n_ymax = r_p1;
                else if (q2 == psbb_pkg::QUAD_I)      n_ymax = r_pr[D2S2];
                else                                  n_ymax = r_p2;
            end
            psbb_pkg::QUAD_II: begin
                priority if (q2 == psbb_pkg::QUAD_I)
                    n_ymax = psbb_pkg::smax(r_pr[D2S1], r_pr[D2S2]);
                else if (lt)                          n_ymax = r_p2;
                else                                  n_ymax = r_pr[D2S1];
            end
            psbb_pkg::QUAD_III: begin
                priority if (q2 == psbb_pkg::QUAD_I || q2 == psbb_pkg::QUAD_II)
                    n_ymax = r_p2;
                else if (lt)                          n_ymax = r_pr[D1S2];
                else if (q2 == psbb_pkg::QUAD_III)    n_ymax = r_pr[D1S1];
                else    n_ymax = psbb_pkg::smax(r_pr[D1S2], r_pr[D1S1]);
            end
            default: begin
                priority if (q2 == psbb_pkg::QUAD_I)  n_ymax = r_pr[D2S2];
                else if (lt)                          n_ymax = r_p2;
                else                                  n_ymax = r_pr[D1S2];
            end
        endcase
    end

    always_comb begin
        unique case (q1)
            psbb_pkg::QUAD_I: begin
                priority if (lt)                      n_right = r_p2;
                else if (q2 == psbb_pkg::QUAD_I || q2 == psbb_pkg::QUAD_II)
                    n_right = r_pr[D2C1];
                else                                  n_right = r_p2;
            end
            psbb_pkg::QUAD_II: begin
                priority if (lt)                      n_right = r_p2;
                else if (q2 == psbb_pkg::QUAD_I || q2 == psbb_pkg::QUAD_II)
                    n_right = r_pr[D1C1];
                else if (q2 == psbb_pkg::QUAD_III)
                    n_right = psbb_pkg::smax(r_pr[D1C1], r_pr[D1C2]);
                else                                  n_right = r_pr[D2C2];
            end
            psbb_pkg::QUAD_III: begin
                priority if (lt)                      n_right = r_p2;
                else if (q2 != psbb_pkg::QUAD_IV)     n_right = r_pr[D1C2];
                else                                  n_right = r_pr[D2C2];
            end
            default: begin
                priority if (lt)                      n_right = r_p2;
                else                                  n_right = r_pr[D2C2];
            end
        endcase
    end

    always_comb begin
        unique case (q1)
            psbb_pkg::QUAD_I: begin
                priority if (lt)                      n_ymin = -r_p1;
                else if (q2 == psbb_pkg::QUAD_I)      n_ymin = r_pr[D1S1];
                else if (q2 == psbb_pkg::QUAD_II)
                    n_ymin = psbb_pkg::smin(r_pr[D1S1], r_pr[D1S2]);
                else                                  n_ymin = -r_p2;
            end
            psbb_pkg::QUAD_II: begin
                priority if (lt)                      n_ymin = -r_p1;
                else if (q2 == psbb_pkg::QUAD_I || q2 == psbb_pkg::QUAD_II)
                    n_ymin = r_pr[D1S2];
                else if (q2 == psbb_pkg::QUAD_III)    n_ymin = r_pr[D2S2];
                else                                  n_ymin = -r_p2;
            end
            psbb_pkg::QUAD_III: begin
                priority if (lt)                      n_ymin = -r_p2;
                else if (q2 != psbb_pkg::QUAD_IV)     n_ymin = r_pr[D2S2];
                else                                  n_ymin = -r_p2;
            end
            default: begin
                priority if (q2 == psbb_pkg::QUAD_I || q2 == psbb_pkg::QUAD_II)
                    n_ymin = r_pr[D2S1];
                else if (q2 == psbb_pkg::QUAD_III)
                    n_ymin = psbb_pkg::smin(r_pr[D2S1], r_pr[D2S2]);
                else if (lt)                          n_ymin = -r_p2;
                else                                  n_ymin = r_pr[D2S1];
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (adv) begin
            r_o_vld <= r_pr_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_left   <= n_left;
            r_top    <= -n_ymax;
            r_right  <= n_right;
            r_bottom <= -n_ymin;
        end
    end

    assign o_out_ch.valid      = r_o_vld;
    assign o_out_ch.box_left   = r_left;
    assign o_out_ch.box_top    = r_top;
    assign o_out_ch.box_right  = r_right;
    assign o_out_ch.box_bottom = r_bottom;

endmodule

// File: tb/psbb_tb_if.sv
// Testbench constants used by the bench.
`timescale 1ns / 1ps
package psbb_tb_pkg;
    localparam int LATENCY = 28;
endpackage

// File: tb/polar_sector_bounding_box_tb.sv
// Testbench for the sector bounding box block: random and directed sectors, checked against a predictor.
`timescale 1ns / 1ps
module polar_sector_bounding_box_tb;

    typedef struct packed {
        logic [15:0] a1;
        logic [15:0] a2;
        logic [15:0] ri;
        logic [15:0] ro;
    } t_sector;

    typedef struct packed {
        logic signed [16:0] lft;
        logic signed [16:0] top;
        logic signed [16:0] rgt;
        logic signed [16:0] bot;
    } t_box;

    localparam int H = 16384;
    localparam int P = 32768;
    localparam int T = 49152;
    localparam longint ATAN_TAB [0:23] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772,
        166886, 83443, 41722, 20861, 10430, 5215,
        2608, 1304, 652, 326, 163, 81
    };

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    psbb_in_if  in_ch ();
    psbb_out_if out_ch ();

    polar_sector_bounding_box dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in_ch  (in_ch.sink),
        .o_out_ch (out_ch.source)
    );

    t_box   expected_boxes[$];
    int     failures = 0;
    int     sent = 0;
    int     received = 0;
    int     idle_cycles = 0;
    int     send_idle_pct = 0;
    int     recv_stall_pct = 0;
    bit     hold_off = 1'b0;

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        in_ch.valid = 1'b0;
        in_ch.angle_start = '0;
        in_ch.angle_end = '0;
        in_ch.radius_inner = '0;
        in_ch.radius_outer = '0;
    end

    function automatic int q15(longint v);
        longint r;
        r = (v + 16384) >>> 15;
        if (r < 0) r = 0;
        if (r > 32768) r = 32768;
        return int'(r);
    endfunction

    function automatic void sin_cos(int ang, output int sn, output int cs);
        longint unsigned ph;
        int quad;
        longint x, y, z, dx, dy;
        int s, c;
        ph = (longint'(ang) << 16) & 64'hFFFF_FFFF;
        quad = int'(ph >> 30);
        z = longint'(ph & 64'h3FFF_FFFF);
        if (z == 0) begin
            s = 0;
            c = 32768;
        end else begin
            x = 64'h26DD3B6A;
            y = 0;
            for (int i = 0; i < 24; i++) begin
                dx = y >>> i;
                dy = x >>> i;
                if (z >= 0) begin
                    x -= dx; y += dy; z -= ATAN_TAB[i];
                end else begin
                    x += dx; y -= dy; z += ATAN_TAB[i];
                end
            end
            s = q15(y);
            c = q15(x);
        end
        case (quad)
            0: begin sn = s; cs = c; end
            1: begin sn = c; cs = -s; end
            2: begin sn = -s; cs = -c; end
            default: begin sn = -c; cs = s; end
        endcase
    endfunction

    function automatic int scale(int r, int t);
        longint m;
        m = (longint'(r) * longint'(t < 0 ? -t : t) + 16384) >>> 15;
        if (m > 65535) m = 65535;
        return t < 0 ? -int'(m) : int'(m);
    endfunction

    function automatic int imin(int a, int b); return a < b ? a : b; endfunction
    function automatic int imax(int a, int b); return a > b ? a : b; endfunction

    function automatic t_box sector_box(t_sector s);
        int a1, a2, d1, d2, s1, c1, s2, c2, p1, p2, l, ym, r, yn;
        t_box b;
        a1 = s.a1; a2 = s.a2; d1 = s.ri; d2 = s.ro;
        p1 = scale(d1, 32768);
        p2 = scale(d2, 32768);
        sin_cos(a1, s1, c1);
        sin_cos(a2, s2, c2);
        if (a1 < H) begin
            if (a2 < a1) l = -p2;
            else if (a2 < H) l = scale(d1, c2);
            else if (a2 < P) l = scale(d2, c2);
            else l = -p2;
        end else if (a1 < P) begin
            if (a2 < H) l = -p2;
            else if (a2 < P) l = scale(d2, c2);
            else l = -p2;
        end else if (a1 < T) begin
            if (a2 < H) l = scale(d2, c1);
            else if (a2 < a1) l = imin(scale(d2, c1), scale(d2, c2));
            else l = scale(d2, c1);
        end else begin
            if (a2 < H) l = imin(scale(d1, c1), scale(d1, c2));
            else if (a2 < P) l = scale(d2, c2);
            else if (a2 < a1) l = -p2;
            else l = scale(d1, c1);
        end
        if (a1 < H) begin
            if (a2 < a1) ym = p1;
            else if (a2 < H) ym = scale(d2, s2);
            else ym = p2;
        end else if (a1 < P) begin
            if (a2 < H) ym = imax(scale(d2, s1), scale(d2, s2));
            else if (a2 < a1) ym = p2;
            else ym = scale(d2, s1);
        end else if (a1 < T) begin
            if (a2 < P) ym = p2;
            else if (a2 < a1) ym = scale(d1, s2);
            else if (a2 < T) ym = scale(d1, s1);
            else ym = imax(scale(d1, s2), scale(d1, s1));
        end else begin
            if (a2 < H) ym = scale(d2, s2);
            else if (a2 < a1) ym = p2;
            else ym = scale(d1, s2);
        end
        if (a1 < H) begin
            if (a2 < a1) r = p2;
            else if (a2 < P) r = scale(d2, c1);
            else r = p2;
        end else if (a1 < P) begin
            if (a2 < a1) r = p2;
            else if (a2 < P) r = scale(d1, c1);
            else if (a2 < T) r = imax(scale(d1, c1), scale(d1, c2));
            else r = scale(d2, c2);
        end else if (a1 < T) begin
            if (a2 < a1) r = p2;
            else if (a2 < T) r = scale(d1, c2);
            else r = scale(d2, c2);
        end else begin
            if (a2 < a1) r = p2;
            else r = scale(d2, c2);
        end
        if (a1 < H) begin
            if (a2 < a1) yn = -p1;
            else if (a2 < H) yn = scale(d1, s1);
            else if (a2 < P) yn = imin(scale(d1, s1), scale(d1, s2));
            else yn = -p2;
        end else if (a1 < P) begin
            if (a2 < a1) yn = -p1;
            else if (a2 < P) yn = scale(d1, s2);
            else if (a2 < T) yn = scale(d2, s2);
            else yn = -p2;
        end else if (a1 < T) begin
            if (a2 < a1) yn = -p2;
            else if (a2 < T) yn = scale(d2, s2);
            else yn = -p2;
        end else begin
            if (a2 < P) yn = scale(d2, s1);
            else if (a2 < T) yn = imin(scale(d2, s1), scale(d2, s2));
            else if (a2 < a1) yn = -p2;
            else yn = scale(d2, s1);
        end
        b.lft = l[16:0];
        b.top = 17'(-ym);
        b.rgt = r[16:0];
        b.bot = 17'(-yn);
        return b;
    endfunction

    // receiver: random stalls, plus a long hold-off on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_box got, want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got = '{out_ch.box_left, out_ch.box_top, out_ch.box_right, out_ch.box_bottom};
            received++;
            if (expected_boxes.size() == 0) begin
                $display("%0t: unexpected box %h", $time, got);
                failures++;
            end else begin
                want = expected_boxes.pop_front();
                if (got.lft !== want.lft)
                    $display("%0t: left exp %0d got %0d", $time, want.lft, got.lft);
                if (got.top !== want.top)
                    $display("%0t: top exp %0d got %0d", $time, want.top, got.top);
                if (got.rgt !== want.rgt)
                    $display("%0t: right exp %0d got %0d", $time, want.rgt, got.rgt);
                if (got.bot !== want.bot)
                    $display("%0t: bottom exp %0d got %0d", $time, want.bot, got.bot);
                if (got !== want) failures++;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 5000) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // valid stays high after an accept so that the next item can follow at once
    task automatic send_sector(t_sector s);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.angle_start <= s.a1;
        in_ch.angle_end <= s.a2;
        in_ch.radius_inner <= s.ri;
        in_ch.radius_outer <= s.ro;
        do @(posedge i_clk); while (!in_ch.ready);
        expected_boxes.push_back(sector_box(s));
        sent++;
    endtask

    function automatic logic [15:0] pick_angle();
        case ($urandom_range(5))
            0: return 16'(H * $urandom_range(3));
            1: return 16'(H * $urandom_range(3) - 1);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick_radius();
        case ($urandom_range(4))
            0: return 16'hFFFF;
            1: return 16'($urandom_range(3));
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic test_directed();
        logic [15:0] ang [0:5];
        ang = '{16'd0, 16'(H - 1), 16'(H), 16'(P), 16'(T), 16'hFFFF};
        for (int i = 0; i < 6; i++)
            for (int j = 0; j < 4; j++)
                send_sector('{ang[i], ang[(i + j + 1) % 6], 16'(j * 9000), 16'hFFFF - 16'(j)});
        send_sector('{16'hF000, 16'hE000, 16'd500, 16'd40000});
    endtask

    task automatic test_random(int n);
        for (int i = 0; i < n; i++)
            send_sector('{pick_angle(), pick_angle(), pick_radius(), pick_radius()});
    endtask

    task automatic test_backpressure();
        hold_off = 1'b1;
        fork
            test_random(60);
            begin
                repeat (200) @(posedge i_clk);
                hold_off = 1'b0;
            end
        join
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(170);
        send_idle_pct = 73;
        test_random(170);
        send_idle_pct = 0;
        recv_stall_pct = 73;
        test_random(170);
        send_idle_pct = 34;
        recv_stall_pct = 34;
        test_random(170);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        test_backpressure();
        in_ch.valid <= 1'b0;
        while (expected_boxes.size() != 0) @(posedge i_clk);
        repeat (psbb_tb_pkg::LATENCY + 12) @(posedge i_clk);
        $display("Sent %0d sectors over quadrant corners, wraps and random angles/radii;",
                 sent);
        $display("%0d boxes checked under sender gaps, receiver stalls and a long hold-off.",
                 received);
        if (failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
